>>> design/trpd_pkg.sv
// shared constants, codes and types of the triangle pixel depth test
`default_nettype none

package trpd_pkg;

    // fixed field widths
    localparam int COORD_W  = 16;
    localparam int DEPTH_W  = 32;
    localparam int COLOR_W  = 32;
    localparam int PIX_W    = 12;
    localparam int CANVAS_W = 13;

    // screen and canvas constants
    localparam int SUBPIXEL_BITS = 4;
    localparam int MAX_SIDE      = 4096;

    // canvas size after reset
    localparam logic [CANVAS_W-1:0] CANVAS_W_RESET = CANVAS_W'(640);
    localparam logic [CANVAS_W-1:0] CANVAS_H_RESET = CANVAS_W'(480);

    // default depth of the front to back queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // area and reciprocal
    localparam int AREA_W      = 36;
    localparam int RECIP_W     = 40;
    localparam int RECIP_SHIFT = 39;
    localparam int WEIGHT_FRAC = 30;

    // derived widths of the edge arithmetic
    localparam int DBL_W  = COORD_W + 1;                 // doubled vertex coordinate
    localparam int APR_W  = 2 * DBL_W;                   // area partial product
    localparam int PC_W   = PIX_W + 1 + SUBPIXEL_BITS;   // pixel centre, unsigned
    localparam int DP_W   = ((PC_W + 1 > DBL_W) ? PC_W + 1 : DBL_W) + 1;
    localparam int DE_W   = DBL_W + 1;                   // edge delta
    localparam int PR_W   = DP_W + DE_W;                 // edge product
    localparam int NW_W   = PR_W + 1;                    // negated edge weight
    localparam int SPLIT  = 21;                          // partial product split
    localparam int WT_W   = WEIGHT_FRAC + 1;             // barycentric weight
    localparam int PROD_W = WT_W + RECIP_SHIFT + 2 - WEIGHT_FRAC;
    localparam int ACC_W  = 64;                          // depth accumulator
    localparam int ZQ_W   = ACC_W - WEIGHT_FRAC;         // shifted depth

    // item classes
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_SETUP = 2'd1;
    localparam logic [1:0] KIND_NOP   = 2'd2;

    // one classified item in the queue
    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          vi;
        logic [COORD_W-1:0]  vx;
        logic [COORD_W-1:0]  vy;
        logic [DEPTH_W-1:0]  vz;
        logic [COLOR_W-1:0]  color;
        logic [PIX_W-1:0]    px;
        logic [PIX_W-1:0]    py;
        logic [DEPTH_W-1:0]  sd;
        logic                in_canvas;
    } entry_t;

    // triangle state seen by the pixel pipeline
    typedef struct packed {
        logic [2:0][COORD_W-1:0] vx;
        logic [2:0][COORD_W-1:0] vy;
        logic [2:0][DEPTH_W-1:0] vz;
        logic [RECIP_W-1:0]      recip;
        logic                    front_facing;
        logic [COLOR_W-1:0]      color;
    } geom_t;

endpackage

`default_nettype wire

>>> design/trpd_front.sv
// front end: accepts items, classifies them and clips pixels to the canvas
`default_nettype none

module trpd_front
    import trpd_pkg::*;
(
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  func,
    input  wire logic [1:0]            vertex_index,
    input  wire logic [COORD_W-1:0]    vert_x,
    input  wire logic [COORD_W-1:0]    vert_y,
    input  wire logic [DEPTH_W-1:0]    vert_z,
    input  wire logic [COLOR_W-1:0]    color_in,
    input  wire logic [PIX_W-1:0]      pixel_x,
    input  wire logic [PIX_W-1:0]      pixel_y,
    input  wire logic [DEPTH_W-1:0]    stored_depth,
    input  wire logic [CANVAS_W-1:0]   canvas_width,
    input  wire logic [CANVAS_W-1:0]   canvas_height,
    input  wire logic                  q_full,
    output logic                       push,
    output entry_t                     entry
);

    logic in_x;
    logic in_y;

    // handshake towards the queue
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // canvas clip against the register and the side limit
    assign in_x = ({1'b0, pixel_x} < canvas_width) && (32'(pixel_x) < MAX_SIDE);
    assign in_y = ({1'b0, pixel_y} < canvas_height) && (32'(pixel_y) < MAX_SIDE);

    // classify the beat
    always_comb
    begin
        entry           = '0;
        entry.vi        = vertex_index;
        entry.vx        = vert_x;
        entry.vy        = vert_y;
        entry.vz        = vert_z;
        entry.color     = color_in;
        entry.px        = pixel_x;
        entry.py        = pixel_y;
        entry.sd        = stored_depth;
        entry.in_canvas = in_x && in_y;
        if (func)
        begin
            entry.kind = KIND_PIXEL;
        end
        else if (vertex_index == 2'd3)
        begin
            entry.kind = KIND_NOP;
        end
        else
        begin
            entry.kind = KIND_SETUP;
        end
    end

endmodule

`default_nettype wire

>>> design/trpd_queue.sv
// short fifo of classified items between the front end and the back end
`default_nettype none

module trpd_queue
    import trpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  entry_t      wr_entry,
    input  wire logic   pop,
    output entry_t      head,
    output logic        full,
    output logic        empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slot_reg [DEPTH];
    logic [IW-1:0]   wr_ptr_reg;
    logic [IW-1:0]   wr_ptr_next;
    logic [IW-1:0]   rd_ptr_reg;
    logic [IW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

>>> design/trpd_setup.sv
// triangle setup: corner store, signed area and bit-serial reciprocal
`default_nettype none

module trpd_setup
    import trpd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   upd,
    input  entry_t      entry,
    output geom_t       geom,
    output logic        busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_AREA = 2'd1;
    localparam logic [1:0] ST_SUB  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;
    localparam int         CNT_W   = $clog2(RECIP_W);

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [2:0][COORD_W-1:0]   vx_reg;
    logic [2:0][COORD_W-1:0]   vy_reg;
    logic [2:0][DEPTH_W-1:0]   vz_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic signed [APR_W-1:0]   pa_reg;
    logic signed [APR_W-1:0]   pa_next;
    logic signed [APR_W-1:0]   pb_reg;
    logic signed [APR_W-1:0]   pb_next;
    logic signed [AREA_W-1:0]  area_reg;
    logic signed [AREA_W-1:0]  area_next;
    logic [AREA_W-1:0]         div_reg;
    logic [AREA_W-1:0]         div_next;
    logic [AREA_W-1:0]         rem_reg;
    logic [AREA_W-1:0]         rem_next;
    logic [RECIP_W-1:0]        quo_reg;
    logic [RECIP_W-1:0]        quo_next;
    logic [RECIP_W-1:0]        recip_reg;
    logic [RECIP_W-1:0]        recip_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      ff_reg;
    logic                      ff_next;
    logic signed [DBL_W-1:0]   ex1;
    logic signed [DBL_W-1:0]   ey1;
    logic signed [DBL_W-1:0]   ex2;
    logic signed [DBL_W-1:0]   ey2;
    logic [AREA_W:0]           trial;
    logic                      qbit;

    assign busy = (state_reg != ST_IDLE);

    assign geom.vx           = vx_reg;
    assign geom.vy           = vy_reg;
    assign geom.vz           = vz_reg;
    assign geom.recip        = recip_reg;
    assign geom.front_facing = ff_reg;
    assign geom.color        = color_reg;

    // corner deltas for the area
    assign ex1 = DBL_W'($signed(vx_reg[1])) - DBL_W'($signed(vx_reg[0]));
    assign ey1 = DBL_W'($signed(vy_reg[1])) - DBL_W'($signed(vy_reg[0]));
    assign ex2 = DBL_W'($signed(vx_reg[2])) - DBL_W'($signed(vx_reg[0]));
    assign ey2 = DBL_W'($signed(vy_reg[2])) - DBL_W'($signed(vy_reg[0]));

    // restoring division step, dividend is a single one bit
    assign trial = {rem_reg, (cnt_reg == CNT_W'(RECIP_SHIFT))};
    assign qbit  = (trial >= {1'b0, div_reg});

    // setup sequencer
    always_comb
    begin
        state_next = state_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        area_next  = area_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        recip_next = recip_reg;
        cnt_next   = cnt_reg;
        ff_next    = ff_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (upd && entry.kind == KIND_SETUP && entry.vi == 2'd2)
                begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                pa_next    = ex2 * ey1;
                pb_next    = ey2 * ex1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                area_next = AREA_W'(pa_reg) - AREA_W'(pb_reg);
                div_next  = AREA_W'(pb_reg) - AREA_W'(pa_reg);
                ff_next   = area_next < 0;
                rem_next  = '0;
                quo_next  = '0;
                cnt_next  = CNT_W'(RECIP_W - 1);
                if (ff_next)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    recip_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                rem_next = qbit ? AREA_W'(trial - {1'b0, div_reg}) : trial[AREA_W-1:0];
                quo_next = {quo_reg[RECIP_W-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    recip_next = quo_next;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and triangle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vx_reg    <= '0;
            vy_reg    <= '0;
            vz_reg    <= '0;
            color_reg <= '0;
            area_reg  <= '0;
            recip_reg <= '0;
            ff_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            area_reg  <= area_next;
            recip_reg <= recip_next;
            ff_reg    <= ff_next;
            cnt_reg   <= cnt_next;
            if (upd && entry.kind == KIND_SETUP)
            begin
                vx_reg[entry.vi] <= entry.vx;
                vy_reg[entry.vi] <= entry.vy;
                vz_reg[entry.vi] <= entry.vz;
                if (entry.vi == 2'd0)
                begin
                    color_reg <= entry.color;
                end
            end
        end
    end

    // datapath of the area and divider
    always_ff @(posedge clk)
    begin
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

>>> design/trpd_pixel_pipe.sv
// back end: pipelined edge test, depth interpolation and result register
`default_nettype none

module trpd_pixel_pipe
    import trpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  issue,
    input  entry_t                     head,
    input  geom_t                      geom,
    output logic                       adv,
    output logic                       pipe_empty,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       covered,
    output logic                       depth_write,
    output logic [PIX_W-1:0]           out_x,
    output logic [PIX_W-1:0]           out_y,
    output logic [DEPTH_W-1:0]         new_depth,
    output logic [COLOR_W-1:0]         color_out
);

    localparam int NST = 7;
    localparam int EA [3] = '{1, 2, 0};
    localparam int EB [3] = '{2, 0, 1};

    typedef struct packed {
        logic                is_pix;
        logic                in_canvas;
        logic                cov;
        logic [PIX_W-1:0]    px;
        logic [PIX_W-1:0]    py;
        logic [DEPTH_W-1:0]  sd;
    } info_t;

    logic [NST-1:0]                valid_reg;
    info_t                         info_reg [NST];
    logic signed [PR_W-1:0]        p1_reg [3];
    logic signed [PR_W-1:0]        p2_reg [3];
    logic signed [NW_W-1:0]        nw_reg [3];
    logic [PROD_W-1:0]             ll_reg [3];
    logic [PROD_W-SPLIT-1:0]       hl_reg [3];
    logic [PROD_W-SPLIT-1:0]       lh_reg [3];
    logic [WT_W-1:0]               wt_reg [3];
    logic signed [ACC_W-1:0]       m_reg [3];
    logic signed [ACC_W-1:0]       s_reg;

    logic signed [PR_W-1:0]        p1_next [3];
    logic signed [PR_W-1:0]        p2_next [3];
    logic signed [NW_W-1:0]        nw_next [3];
    logic [PROD_W-1:0]             ll_next [3];
    logic [PROD_W-SPLIT-1:0]       hl_next [3];
    logic [PROD_W-SPLIT-1:0]       lh_next [3];
    logic [WT_W-1:0]               wt_next [3];
    logic signed [ACC_W-1:0]       m_next [3];
    logic signed [ACC_W-1:0]       s_next;
    logic                          cov_next;
    info_t                         stage2_info;

    logic [PC_W-1:0]               pcx;
    logic [PC_W-1:0]               pcy;
    logic signed [DP_W-1:0]        dxp;
    logic signed [DP_W-1:0]        dyp;
    logic signed [DE_W-1:0]        dxe;
    logic signed [DE_W-1:0]        dye;
    logic [NW_W-1:0]               full_hl;
    logic [NW_W-1:0]               full_lh;
    logic [PROD_W-SPLIT-1:0]       mid;
    logic [PROD_W-1:0]             prod;
    logic signed [ZQ_W-1:0]        zq;
    logic [DEPTH_W-1:0]            zsat;
    logic                          wr;

    logic                          out_valid_reg;
    logic                          covered_reg;
    logic                          depth_write_reg;
    logic [PIX_W-1:0]              out_x_reg;
    logic [PIX_W-1:0]              out_y_reg;
    logic [DEPTH_W-1:0]            new_depth_reg;
    logic [COLOR_W-1:0]            color_out_reg;

    // whole pipeline moves when the result register can take a beat
    assign adv        = !out_valid_reg || !out_stall;
    assign pipe_empty = (valid_reg == '0);

    // pixel centre at twice the subpixel scale
    assign pcx = PC_W'({info_reg[0].px, 1'b1}) << SUBPIXEL_BITS;
    assign pcy = PC_W'({info_reg[0].py, 1'b1}) << SUBPIXEL_BITS;

    // edge products from the pixel and corner deltas
    always_comb
    begin
        dxp = '0;
        dyp = '0;
        dxe = '0;
        dye = '0;
        for (int e = 0; e < 3; e++)
        begin
            dxp = DP_W'($signed({1'b0, pcx})) -
                  DP_W'($signed({geom.vx[EA[e]], 1'b0}));
            dyp = DP_W'($signed({1'b0, pcy})) -
                  DP_W'($signed({geom.vy[EA[e]], 1'b0}));
            dxe = DE_W'($signed({geom.vx[EB[e]], 1'b0})) -
                  DE_W'($signed({geom.vx[EA[e]], 1'b0}));
            dye = DE_W'($signed({geom.vy[EB[e]], 1'b0})) -
                  DE_W'($signed({geom.vy[EA[e]], 1'b0}));
            p1_next[e] = dxp * dye;
            p2_next[e] = dyp * dxe;
        end
    end

    // negated edge weights and coverage
    always_comb
    begin
        cov_next = info_reg[1].is_pix && info_reg[1].in_canvas && geom.front_facing;
        for (int e = 0; e < 3; e++)
        begin
            nw_next[e] = NW_W'(p2_reg[e]) - NW_W'(p1_reg[e]);
            cov_next   = cov_next && !nw_next[e][NW_W-1];
        end
    end

    // item info entering the third stage carries the coverage
    always_comb
    begin
        stage2_info     = info_reg[1];
        stage2_info.cov = cov_next;
    end

    // weight times reciprocal, split into partial products
    always_comb
    begin
        full_hl = '0;
        full_lh = '0;
        for (int e = 0; e < 3; e++)
        begin
            ll_next[e] = PROD_W'(nw_reg[e][SPLIT-1:0] * geom.recip[SPLIT-1:0]);
            full_hl    = NW_W'(nw_reg[e][NW_W-1:SPLIT] * geom.recip[SPLIT-1:0]);
            full_lh    = NW_W'(nw_reg[e][SPLIT-1:0] * geom.recip[RECIP_W-1:SPLIT]);
            hl_next[e] = full_hl[PROD_W-SPLIT-1:0];
            lh_next[e] = full_lh[PROD_W-SPLIT-1:0];
        end
    end

    // recombine the partial products into a barycentric weight
    always_comb
    begin
        mid  = '0;
        prod = '0;
        for (int e = 0; e < 3; e++)
        begin
            mid        = hl_reg[e] + lh_reg[e];
            prod       = ll_reg[e] + {mid, {SPLIT{1'b0}}};
            wt_next[e] = prod[PROD_W-1:PROD_W-WT_W];
        end
    end

    // weight times corner depth
    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            m_next[e] = $signed({1'b0, wt_reg[e]}) * $signed(geom.vz[e]);
        end
    end

    // depth sum
    assign s_next = m_reg[0] + m_reg[1] + m_reg[2];

    // floor shift, saturation and depth compare
    assign zq = s_reg[ACC_W-1:WEIGHT_FRAC];
    always_comb
    begin
        if (zq[ZQ_W-1:DEPTH_W-1] != {(ZQ_W - DEPTH_W + 1){zq[ZQ_W-1]}})
        begin
            zsat = zq[ZQ_W-1] ? {1'b1, {(DEPTH_W - 1){1'b0}}} : {1'b0, {(DEPTH_W - 1){1'b1}}};
        end
        else
        begin
            zsat = zq[DEPTH_W-1:0];
        end
    end
    assign wr = $signed(zsat) < $signed(info_reg[NST-1].sd);

    // stage valid bits and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[NST-2:0], issue};
            out_valid_reg <= valid_reg[NST-1];
        end
    end

    // item info and datapath stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info_reg[0].is_pix    <= (head.kind == KIND_PIXEL);
            info_reg[0].in_canvas <= head.in_canvas;
            info_reg[0].cov       <= 1'b0;
            info_reg[0].px        <= head.px;
            info_reg[0].py        <= head.py;
            info_reg[0].sd        <= head.sd;
            for (int k = 1; k < NST; k++)
            begin
                info_reg[k] <= (k == 2) ? stage2_info : info_reg[k-1];
            end
            for (int e = 0; e < 3; e++)
            begin
                p1_reg[e] <= p1_next[e];
                p2_reg[e] <= p2_next[e];
                nw_reg[e] <= nw_next[e];
                ll_reg[e] <= ll_next[e];
                hl_reg[e] <= hl_next[e];
                lh_reg[e] <= lh_next[e];
                wt_reg[e] <= wt_next[e];
                m_reg[e]  <= m_next[e];
            end
            s_reg <= s_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            covered_reg     <= info_reg[NST-1].cov;
            depth_write_reg <= info_reg[NST-1].cov && wr;
            out_x_reg       <= info_reg[NST-1].is_pix ? info_reg[NST-1].px : '0;
            out_y_reg       <= info_reg[NST-1].is_pix ? info_reg[NST-1].py : '0;
            new_depth_reg   <= info_reg[NST-1].cov ? zsat : '0;
            color_out_reg   <= (info_reg[NST-1].cov && wr) ? geom.color : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign covered     = covered_reg;
    assign depth_write = depth_write_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign new_depth   = new_depth_reg;
    assign color_out   = color_out_reg;

endmodule

`default_nettype wire

>>> design/triangle_pixel_depth_test_core.sv
// Triangle pixel depth test: top level with the register port and item issue.
// A pixel beat is issued from the queue into seven pipeline stages, then the result
// register; one pixel per clock while neither out_stall nor a busy setup holds issue.
// A setup beat waits for the pipeline to drain; corner 2 then holds issue through the
// area products, subtract and, if front-facing, 40 steps of the bit-serial divider.
// Reset (rst_n, asynchronous, active low) clears corners, area, reciprocal, colour
// and facing, empties queue and pipeline, and sets the canvas to 640 by 480.
`default_nettype none

module triangle_pixel_depth_test_core
    import trpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  func,
    input  wire logic [1:0]            vertex_index,
    input  wire logic [COORD_W-1:0]    vert_x,
    input  wire logic [COORD_W-1:0]    vert_y,
    input  wire logic [DEPTH_W-1:0]    vert_z,
    input  wire logic [COLOR_W-1:0]    color_in,
    input  wire logic [PIX_W-1:0]      pixel_x,
    input  wire logic [PIX_W-1:0]      pixel_y,
    input  wire logic [DEPTH_W-1:0]    stored_depth,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       covered,
    output logic                       depth_write,
    output logic [PIX_W-1:0]           out_x,
    output logic [PIX_W-1:0]           out_y,
    output logic [DEPTH_W-1:0]         new_depth,
    output logic [COLOR_W-1:0]         color_out
);

    logic [CANVAS_W-1:0]  cw_reg;
    logic [CANVAS_W-1:0]  ch_reg;
    logic                 cfg_wr;
    logic                 push;
    entry_t               wr_entry;
    entry_t               head;
    logic                 q_full;
    logic                 q_empty;
    logic                 issue;
    logic                 upd;
    logic                 setup_busy;
    logic                 adv;
    logic                 pipe_empty;
    geom_t                geom;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(ch_reg) : 32'(cw_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= CANVAS_W_RESET;
            ch_reg <= CANVAS_H_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                ch_reg <= pwdata[CANVAS_W-1:0];
            end
            else
            begin
                cw_reg <= pwdata[CANVAS_W-1:0];
            end
        end
    end

    trpd_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .vertex_index  (vertex_index),
        .vert_x        (vert_x),
        .vert_y        (vert_y),
        .vert_z        (vert_z),
        .color_in      (color_in),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .stored_depth  (stored_depth),
        .canvas_width  (cw_reg),
        .canvas_height (ch_reg),
        .q_full        (q_full),
        .push          (push),
        .entry         (wr_entry)
    );

    trpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (issue),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // issue: pixels stream, setup beats wait for an empty pipeline
    assign issue = !q_empty && !setup_busy && adv &&
                   ((head.kind == KIND_PIXEL) || pipe_empty);
    assign upd   = issue && (head.kind != KIND_PIXEL);

    trpd_setup u_setup (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .entry (head),
        .geom  (geom),
        .busy  (setup_busy)
    );

    trpd_pixel_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .head        (head),
        .geom        (geom),
        .adv         (adv),
        .pipe_empty  (pipe_empty),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .covered     (covered),
        .depth_write (depth_write),
        .out_x       (out_x),
        .out_y       (out_y),
        .new_depth   (new_depth),
        .color_out   (color_out)
    );

    // no issue while the triangle state is being rebuilt
    assert property (@(posedge clk) disable iff (!rst_n) setup_busy |-> !issue)
        else $error("beat issued during triangle setup");

    // setup beats only enter an empty pipeline
    assert property (@(posedge clk) disable iff (!rst_n) upd |-> pipe_empty)
        else $error("setup beat issued behind pixels in flight");

    // loading corner 2 starts the setup sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd && head.kind == KIND_SETUP && head.vi == 2'd2) |=> setup_busy)
        else $error("corner 2 did not start setup");

endmodule

`default_nettype wire

>>> tb/tb_triangle_pixel_depth_test_core.sv
// testbench for the triangle pixel depth test core: directed and random beats checked against a predictor
`timescale 1ns / 100ps

module tb_triangle_pixel_depth_test_core;
    import trpd_pkg::*;

    // operation codes of the func field
    localparam logic FUNC_SETUP = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;
    // register byte addresses
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd4;
    // corner index that loads nothing
    localparam logic [1:0] CORNER_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 5000;

    // one input beat
    typedef struct {
        logic                        func;
        logic [1:0]                  vi;
        logic signed [COORD_W-1:0]   vx;
        logic signed [COORD_W-1:0]   vy;
        logic signed [DEPTH_W-1:0]   vz;
        logic [COLOR_W-1:0]          color;
        logic [PIX_W-1:0]            px;
        logic [PIX_W-1:0]            py;
        logic signed [DEPTH_W-1:0]   sd;
    } raster_beat_t;

    // one result beat
    typedef struct {
        logic                      cov;
        logic                      wr;
        logic [PIX_W-1:0]          x;
        logic [PIX_W-1:0]          y;
        logic [DEPTH_W-1:0]        depth;
        logic [COLOR_W-1:0]        color;
    } depth_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = 1'b0;
    logic [1:0] vertex_index = '0;
    logic [COORD_W-1:0] vert_x = '0, vert_y = '0;
    logic [DEPTH_W-1:0] vert_z = '0;
    logic [COLOR_W-1:0] color_in = '0;
    logic [PIX_W-1:0] pixel_x = '0, pixel_y = '0;
    logic [DEPTH_W-1:0] stored_depth = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic covered, depth_write;
    logic [PIX_W-1:0] out_x, out_y;
    logic [DEPTH_W-1:0] new_depth;
    logic [COLOR_W-1:0] color_out;

    triangle_pixel_depth_test_core dut (.*);

    always #2 clk = ~clk;

    // predictor state
    logic [CANVAS_W-1:0]         pred_width = CANVAS_W_RESET;
    logic [CANVAS_W-1:0]         pred_height = CANVAS_H_RESET;
    logic signed [COORD_W-1:0]   corner_x[3];
    logic signed [COORD_W-1:0]   corner_y[3];
    logic signed [DEPTH_W-1:0]   corner_z[3];
    logic [63:0]                 tri_recip = '0;
    logic                        tri_front = 1'b0;
    logic [COLOR_W-1:0]          tri_color = '0;

    depth_result_t pending_results[$];
    int  error_count = 0;
    int  result_count = 0;
    int  covered_count = 0;
    int  write_count = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    initial begin
        for (int i = 0; i < 3; i++)
        begin
            corner_x[i] = '0;
            corner_y[i] = '0;
            corner_z[i] = '0;
        end
    end

    function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                       longint qx, longint qy);
        return (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
    endfunction

    // updates the triangle state and works out the result of one beat
    function automatic depth_result_t predict_depth(raster_beat_t b);
        depth_result_t r;
        longint area, pcx, pcy, w0, w1, w2, s, z;
        longint x0, y0, x1, y1, x2, y2;
        logic [63:0] a0, a1, a2;
        int wlim, hlim;
        r = '{default: '0};
        if (b.func == FUNC_SETUP) begin
            if (b.vi != CORNER_NONE) begin
                corner_x[b.vi] = b.vx;
                corner_y[b.vi] = b.vy;
                corner_z[b.vi] = b.vz;
                if (b.vi == 2'd0)
                    tri_color = b.color;
                if (b.vi == 2'd2) begin
                    area = edge_fn(corner_x[0], corner_y[0], corner_x[1], corner_y[1],
                                   corner_x[2], corner_y[2]);
                    tri_front = area < 0;
                    tri_recip = tri_front ? (64'd1 << RECIP_SHIFT) / 64'(-area) : 64'd0;
                end
            end
            return r;
        end
        wlim = pred_width < MAX_SIDE ? pred_width : MAX_SIDE;
        hlim = pred_height < MAX_SIDE ? pred_height : MAX_SIDE;
        pcx = ((2 * longint'(b.px)) + 1) << SUBPIXEL_BITS;
        pcy = ((2 * longint'(b.py)) + 1) << SUBPIXEL_BITS;
        x0 = 2 * longint'(corner_x[0]); y0 = 2 * longint'(corner_y[0]);
        x1 = 2 * longint'(corner_x[1]); y1 = 2 * longint'(corner_y[1]);
        x2 = 2 * longint'(corner_x[2]); y2 = 2 * longint'(corner_y[2]);
        w0 = edge_fn(x1, y1, x2, y2, pcx, pcy);
        w1 = edge_fn(x2, y2, x0, y0, pcx, pcy);
        w2 = edge_fn(x0, y0, x1, y1, pcx, pcy);
        r.x = b.px;
        r.y = b.py;
        if (tri_front && b.px < wlim && b.py < hlim && w0 <= 0 && w1 <= 0 && w2 <= 0) begin
            a0 = (64'(-w0) * tri_recip) >> (RECIP_SHIFT + 2 - WEIGHT_FRAC);
            a1 = (64'(-w1) * tri_recip) >> (RECIP_SHIFT + 2 - WEIGHT_FRAC);
            a2 = (64'(-w2) * tri_recip) >> (RECIP_SHIFT + 2 - WEIGHT_FRAC);
            s = longint'(a0) * longint'(corner_z[0]) + longint'(a1) * longint'(corner_z[1])
                + longint'(a2) * longint'(corner_z[2]);
            z = s >>> WEIGHT_FRAC;
            if (z > 64'sd2147483647) z = 64'sd2147483647;
            if (z < -64'sd2147483648) z = -64'sd2147483648;
            r.cov = 1'b1;
            r.wr = z < longint'(b.sd);
            r.depth = z[31:0];
            r.color = r.wr ? tri_color : '0;
        end
        return r;
    endfunction

    // sends one beat, with an occasional gap before it
    task automatic send_beat(raster_beat_t b);
        bit accepted;
        int gap;
        if (!calm && $urandom_range(99) < 8) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= b.func;
        vertex_index <= b.vi;
        vert_x <= b.vx;
        vert_y <= b.vy;
        vert_z <= b.vz;
        color_in <= b.color;
        pixel_x <= b.px;
        pixel_y <= b.py;
        stored_depth <= b.sd;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = !in_stall;
            @(posedge clk);
        end
        pending_results.push_back(predict_depth(b));
    endtask

    task automatic send_corner(logic [1:0] vi, int x, int y, int z, logic [31:0] color);
        raster_beat_t b;
        b = '{func: FUNC_SETUP, vi: vi, vx: COORD_W'(x), vy: COORD_W'(y), vz: z,
              color: color, px: PIX_W'($urandom), py: PIX_W'($urandom), sd: $urandom};
        send_beat(b);
    endtask

    task automatic send_pixel(int x, int y, int sd);
        raster_beat_t b;
        b = '{func: FUNC_PIXEL, vi: 2'($urandom), vx: COORD_W'($urandom),
              vy: COORD_W'($urandom), vz: $urandom, color: $urandom,
              px: PIX_W'(x), py: PIX_W'(y), sd: sd};
        send_beat(b);
    endtask

    // waits until every result is back and the block has gone quiet
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_WIDTH)
            pred_width = value[CANVAS_W-1:0];
        else
            pred_height = value[CANVAS_W-1:0];
    endtask

    task automatic set_canvas(int w, int h);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // reference front-facing triangle used by the directed tests
    task automatic load_square_tri(int z0, int z1, int z2);
        send_corner(2'd0, 0, 0, z0, 32'hA5C3_0F81);
        send_corner(2'd1, 1600, 0, z1, 32'h1234_5678);
        send_corner(2'd2, 0, 1600, z2, 32'hFFFF_FFFF);
    endtask

    // nothing drawn straight after reset, unused corner index
    task automatic test_reset_state;
        send_pixel(0, 0, 32'h7FFF_FFFF);
        send_pixel(4095, 4095, 0);
        send_corner(CORNER_NONE, -32768, 32767, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // covered and uncovered pixels, depth compare both ways
    task automatic test_coverage_and_depth;
        load_square_tri(0, 1 << 16, 2 << 16);
        send_pixel(10, 10, 32'h7FFF_FFFF);
        send_pixel(10, 10, 32'h8000_0000);
        send_pixel(99, 99, 0);
        send_pixel(50, 20, 20 << 16);
        load_square_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pixel(1, 1, 32'h7FFF_FFFF);
        load_square_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pixel(2, 3, 32'h8000_0000);
    endtask

    // back-facing triangles are culled
    task automatic test_culling;
        send_corner(2'd0, 0, 0, 0, 32'h0F0F_0F0F);
        send_corner(2'd1, 0, 1600, 0, 0);
        send_corner(2'd2, 1600, 0, 0, 0);
        send_pixel(10, 10, 32'h7FFF_FFFF);
        send_corner(2'd2, 800, 800, 0, 0);
        send_pixel(10, 10, 32'h7FFF_FFFF);
        send_corner(2'd0, 32767, -32768, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // clipping at the canvas edges and a zero-sized canvas
    task automatic test_canvas_clip;
        set_canvas(5, 7);
        load_square_tri(0, 1 << 16, 2 << 16);
        send_pixel(4, 6, 32'h7FFF_FFFF);
        send_pixel(5, 6, 32'h7FFF_FFFF);
        send_pixel(4, 7, 32'h7FFF_FFFF);
        set_canvas(0, 0);
        send_pixel(0, 0, 32'h7FFF_FFFF);
    endtask

    // well-formed triangles with pixels from their bounding boxes, plus noise
    task automatic test_random(int beats, int span);
        int sent, npix, minx, maxx, miny, maxy;
        int cx[3], cy[3];
        raster_beat_t b;
        sent = 0;
        while (sent < beats)
        begin
            if ($urandom_range(9) == 0) begin
                b.func = 1'($urandom);
                b.vi = 2'($urandom);
                b.vx = COORD_W'($urandom);
                b.vy = COORD_W'($urandom);
                b.vz = $urandom;
                b.color = $urandom;
                b.px = PIX_W'($urandom);
                b.py = PIX_W'($urandom);
                b.sd = $urandom;
                send_beat(b);
                sent++;
            end else begin
                for (int i = 0; i < 3; i++)
                begin
                    cx[i] = $urandom_range(0, span * 16);
                    cy[i] = $urandom_range(0, span * 16);
                    send_corner(2'(i), cx[i], cy[i],
                                ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 20),
                                $urandom);
                end
                minx = cx[0]; maxx = cx[0]; miny = cy[0]; maxy = cy[0];
                for (int i = 1; i < 3; i++)
                begin
                    if (cx[i] < minx) minx = cx[i];
                    if (cx[i] > maxx) maxx = cx[i];
                    if (cy[i] < miny) miny = cy[i];
                    if (cy[i] > maxy) maxy = cy[i];
                end
                npix = $urandom_range(5, 25);
                for (int i = 0; i < npix; i++)
                    send_pixel($urandom_range(minx >> 4, maxx >> 4),
                               $urandom_range(miny >> 4, maxy >> 4),
                               ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 1 << 20));
                sent += 3 + npix;
            end
        end
    endtask

    // output stall and result checking, sampled in the low clock phase
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 8);

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        depth_result_t e;
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb_triangle_pixel_depth_test_core failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                error_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("covered", e.cov, covered);
                check_field("depth_write", e.wr, depth_write);
                check_field("out_x", e.x, out_x);
                check_field("out_y", e.y, out_y);
                check_field("new_depth", e.depth, new_depth);
                check_field("color_out", e.color, color_out);
                covered_count += covered;
                write_count += depth_write;
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_coverage_and_depth();
        test_culling();
        test_canvas_clip();
        set_canvas(640, 480);
        test_random(300, 200);
        set_canvas(4096, 4096);
        calm = 1'b1;
        test_random(250, 300);
        calm = 1'b0;
        set_canvas(8191, 8191);
        test_random(150, 2047);
        set_canvas(1, 4096);
        test_random(100, 8);
        set_canvas(100, 1);
        test_random(100, 120);
        set_canvas(150, 120);
        test_random(300, 180);
        drain();
        $display("run covered %0d result beats, %0d covered pixels, %0d depth writes",
                 result_count, covered_count, write_count);
        $display("canvas sizes from zero to the 13-bit maximum, culled and clipped triangles");
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_triangle_pixel_depth_test_core passed");
        else
            $display("tb_triangle_pixel_depth_test_core failed");
        $finish;
    end

endmodule
